FILE: hw/rtl/orb_pkg.sv
// package: item types and codes for the output reorder buffer
package orb_pkg;

   localparam logic [1:0] CMD_BEGIN  = 2'd0;
   localparam logic [1:0] CMD_FINISH = 2'd1;
   localparam logic [1:0] CMD_FLUSH  = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BELOW   = 2'd1;
   localparam logic [1:0] STATUS_BEYOND  = 2'd2;
   localparam logic [1:0] STATUS_BAD_FIN = 2'd3;

   localparam int unsigned MAX_RESULTS = 32;
   localparam int unsigned THRESH_W = 6;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 6'd16;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] seq_id;
      logic [31:0] record_handle;
      logic        force_req;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        rec_valid;
      logic [31:0] rec_out;
      logic [31:0] rec_seq;
      logic        last;
      logic [31:0] started_total;
      logic [31:0] finished_total;
      logic [31:0] flushed_total;
   } rsp_type;

endpackage

FILE: hw/rtl/output_reorder_buffer.sv
// top level: reorder buffer that releases finished records in sequence order
//
// One item is taken at a time. A begin, a rejected command or an unused command
// passes through accept, window check against the head, and the response.
// A finish that is stored and a flush then scan the finished flags one slot per
// cycle from the head. Each released record is then read from the record memory
// and loaded into the output register once that register is free. The output
// register holds one result and lets the block go on while it waits to be taken.
// Started and finished flags are flip-flops cleared by reset, so no clearing
// pass follows reset. Counters and ids wrap at 2^32.
module output_reorder_buffer #(
   parameter int unsigned WINDOW_DEPTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  orb_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output orb_pkg::rsp_type                   rsp_data,
   input  logic                               csr_wr_en,
   input  logic [orb_pkg::THRESH_W-1:0]       csr_wr_data
);

   localparam int unsigned SW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int unsigned SUMW = SW + 1;
   localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_CHECK    = 6'b000010,
      ST_SCAN     = 6'b000100,
      ST_EMIT_RD  = 6'b001000,
      ST_EMIT_OUT = 6'b010000,
      ST_RESP     = 6'b100000
   } state_type;

   function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] head,
                                             input logic [SW-1:0] off);
      logic [SUMW-1:0] sum;
      sum = {1'b0, head} + {1'b0, off};
      if (sum >= SUMW'(WINDOW_DEPTH)) begin
         sum = sum - SUMW'(WINDOW_DEPTH);
      end
      return sum[SW-1:0];
   endfunction

   state_type state_ff, state_in;

   orb_pkg::req_type req_ff, req_in;
   logic [1:0]  status_ff, status_in;
   logic [31:0] head_seq_ff, head_seq_in;
   logic [SW-1:0] head_slot_ff, head_slot_in;
   logic [31:0] started_cnt_ff, started_cnt_in;
   logic [31:0] finished_cnt_ff, finished_cnt_in;
   logic [31:0] flushed_cnt_ff, flushed_cnt_in;
   logic [orb_pkg::THRESH_W-1:0] thresh_ff, thresh_in;
   logic [CW-1:0] scan_cnt_ff, scan_cnt_in;
   logic [CW-1:0] rel_ff, rel_in;
   logic [CW-1:0] emit_idx_ff, emit_idx_in;
   logic started_ff [WINDOW_DEPTH];
   logic started_in [WINDOW_DEPTH];
   logic finished_ff [WINDOW_DEPTH];
   logic finished_in [WINDOW_DEPTH];
   logic rsp_valid_ff, rsp_valid_in;
   orb_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic          ram_wr_en;
   logic [SW-1:0] ram_wr_addr;
   logic          ram_rd_en;
   logic [SW-1:0] ram_rd_addr;
   logic [31:0]   ram_rd_data;

   logic [31:0]   off;
   logic          in_win;
   logic [1:0]    win_status;
   logic [SW-1:0] chk_slot;
   logic [SW-1:0] scan_slot;
   logic [SW-1:0] emit_slot;
   logic          out_free;
   logic          scan_hit;
   logic          release_ok;
   logic          emit_last;

   orb_ram #(
      .DEPTH (WINDOW_DEPTH),
      .AW    (SW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_ff.record_handle),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign off = req_ff.seq_id - head_seq_ff;
   assign in_win = off < 32'(WINDOW_DEPTH);
   assign win_status = in_win ? orb_pkg::STATUS_OK :
                       (off[31] ? orb_pkg::STATUS_BELOW : orb_pkg::STATUS_BEYOND);
   assign chk_slot = slot_of(head_slot_ff, off[SW-1:0]);
   assign scan_slot = slot_of(head_slot_ff, scan_cnt_ff[SW-1:0]);
   assign emit_slot = slot_of(head_slot_ff, emit_idx_ff[SW-1:0]);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign scan_hit = (scan_cnt_ff != CW'(WINDOW_DEPTH)) && finished_ff[scan_slot];
   assign release_ok = ((req_ff.cmd == orb_pkg::CMD_FLUSH && req_ff.force_req)
                        || 32'(scan_cnt_ff) >= 32'(thresh_ff)) && (scan_cnt_ff != '0);
   assign emit_last = (emit_idx_ff + CW'(1)) == rel_ff;

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      status_in = status_ff;
      head_seq_in = head_seq_ff;
      head_slot_in = head_slot_ff;
      started_cnt_in = started_cnt_ff;
      finished_cnt_in = finished_cnt_ff;
      flushed_cnt_in = flushed_cnt_ff;
      thresh_in = csr_wr_en ? csr_wr_data : thresh_ff;
      scan_cnt_in = scan_cnt_ff;
      rel_in = rel_ff;
      emit_idx_in = emit_idx_ff;
      started_in = started_ff;
      finished_in = finished_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      ram_wr_en = 1'b0;
      ram_wr_addr = chk_slot;
      ram_rd_en = 1'b0;
      ram_rd_addr = emit_slot;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            status_in = orb_pkg::STATUS_OK;
            state_in = ST_RESP;
            case (req_ff.cmd)
               orb_pkg::CMD_BEGIN: begin
                  status_in = win_status;
                  if (in_win) begin
                     started_in[chk_slot] = 1'b1;
                     finished_in[chk_slot] = 1'b0;
                     started_cnt_in = started_cnt_ff + 32'd1;
                  end
               end
               orb_pkg::CMD_FINISH: begin
                  status_in = win_status;
                  if (in_win) begin
                     if (!started_ff[chk_slot] || finished_ff[chk_slot]) begin
                        status_in = orb_pkg::STATUS_BAD_FIN;
                     end else begin
                        ram_wr_en = 1'b1;
                        finished_in[chk_slot] = 1'b1;
                        finished_cnt_in = finished_cnt_ff + 32'd1;
                        scan_cnt_in = '0;
                        state_in = ST_SCAN;
                     end
                  end
               end
               orb_pkg::CMD_FLUSH: begin
                  scan_cnt_in = '0;
                  state_in = ST_SCAN;
               end
               default: begin
                  status_in = orb_pkg::STATUS_OK;
               end
            endcase
         end
         ST_SCAN: begin
            if (scan_hit) begin
               scan_cnt_in = scan_cnt_ff + CW'(1);
            end else if (release_ok) begin
               if (32'(scan_cnt_ff) > orb_pkg::MAX_RESULTS) begin
                  rel_in = CW'(orb_pkg::MAX_RESULTS);
                  flushed_cnt_in = flushed_cnt_ff + orb_pkg::MAX_RESULTS;
               end else begin
                  rel_in = scan_cnt_ff;
                  flushed_cnt_in = flushed_cnt_ff + 32'(scan_cnt_ff);
               end
               emit_idx_in = '0;
               state_in = ST_EMIT_RD;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_EMIT_RD: begin
            ram_rd_en = 1'b1;
            state_in = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.status = orb_pkg::STATUS_OK;
               rsp_data_in.rec_valid = 1'b1;
               rsp_data_in.rec_out = ram_rd_data;
               rsp_data_in.rec_seq = head_seq_ff + 32'(emit_idx_ff);
               rsp_data_in.last = emit_last;
               rsp_data_in.started_total = started_cnt_ff;
               rsp_data_in.finished_total = finished_cnt_ff;
               rsp_data_in.flushed_total = flushed_cnt_ff;
               started_in[emit_slot] = 1'b0;
               finished_in[emit_slot] = 1'b0;
               if (emit_last) begin
                  head_seq_in = head_seq_ff + 32'(rel_ff);
                  head_slot_in = slot_of(head_slot_ff, rel_ff[SW-1:0]);
                  state_in = ST_IDLE;
               end else begin
                  emit_idx_in = emit_idx_ff + CW'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.status = status_ff;
               rsp_data_in.rec_valid = 1'b0;
               rsp_data_in.rec_out = '0;
               rsp_data_in.rec_seq = '0;
               rsp_data_in.last = 1'b1;
               rsp_data_in.started_total = started_cnt_ff;
               rsp_data_in.finished_total = finished_cnt_ff;
               rsp_data_in.flushed_total = flushed_cnt_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_seq_ff <= '0;
         head_slot_ff <= '0;
         started_cnt_ff <= '0;
         finished_cnt_ff <= '0;
         flushed_cnt_ff <= '0;
         thresh_ff <= orb_pkg::THRESH_RESET;
         scan_cnt_ff <= '0;
         rel_ff <= '0;
         emit_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < WINDOW_DEPTH; i++) begin
            started_ff[i] <= 1'b0;
            finished_ff[i] <= 1'b0;
         end
      end else begin
         state_ff <= state_in;
         head_seq_ff <= head_seq_in;
         head_slot_ff <= head_slot_in;
         started_cnt_ff <= started_cnt_in;
         finished_cnt_ff <= finished_cnt_in;
         flushed_cnt_ff <= flushed_cnt_in;
         thresh_ff <= thresh_in;
         scan_cnt_ff <= scan_cnt_in;
         rel_ff <= rel_in;
         emit_idx_ff <= emit_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         started_ff <= started_in;
         finished_ff <= finished_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      status_ff <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

FILE: hw/rtl/orb_ram.sv
// record handle memory: one write port, one read port with registered read data
module orb_ram #(
   parameter int unsigned DEPTH = 32,
   parameter int unsigned AW = 5
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: tb/orb_release_checker.sv
// checker: predicts the in-order release of the reorder buffer and compares every result item
module orb_release_checker #(
   parameter int unsigned DEPTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  orb_pkg::req_type             req_data,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  orb_pkg::rsp_type             rsp_data,
   input  logic                         csr_wr_en,
   input  logic [orb_pkg::THRESH_W-1:0] csr_wr_data,
   output int                           mismatch_count,
   output int                           pending_results,
   output int                           results_checked,
   output logic [31:0]                  window_head
);

   logic [31:0]                  record_mem [DEPTH];
   bit                           started_flag [DEPTH];
   bit                           finished_flag [DEPTH];
   logic [31:0]                  head_seq;
   int unsigned                  head_slot;
   logic [31:0]                  started_count;
   logic [31:0]                  finished_count;
   logic [31:0]                  flushed_count;
   logic [orb_pkg::THRESH_W-1:0] flush_threshold;
   orb_pkg::rsp_type             expected_rsp_q [$];

   task automatic predict_release(input orb_pkg::req_type it);
      logic [31:0]      offset;
      logic [1:0]       status;
      int unsigned      slot;
      int unsigned      run;
      bit               flush_now;
      bit               forced;
      orb_pkg::rsp_type r;
      orb_pkg::rsp_type out_q [$];
      status    = orb_pkg::STATUS_OK;
      flush_now = 1'b0;
      forced    = 1'b0;
      if (it.cmd == orb_pkg::CMD_BEGIN || it.cmd == orb_pkg::CMD_FINISH) begin
         offset = it.seq_id - head_seq;
         if (offset < DEPTH) status = orb_pkg::STATUS_OK;
         else if (offset[31]) status = orb_pkg::STATUS_BELOW;
         else status = orb_pkg::STATUS_BEYOND;
         if (status == orb_pkg::STATUS_OK) begin
            slot = (head_slot + offset) % DEPTH;
            if (it.cmd == orb_pkg::CMD_BEGIN) begin
               started_flag[slot]  = 1'b1;
               finished_flag[slot] = 1'b0;
               started_count++;
            end else if (!started_flag[slot] || finished_flag[slot]) begin
               status = orb_pkg::STATUS_BAD_FIN;
            end else begin
               record_mem[slot]    = it.record_handle;
               finished_flag[slot] = 1'b1;
               finished_count++;
               flush_now = 1'b1;
            end
         end
      end else if (it.cmd == orb_pkg::CMD_FLUSH) begin
         flush_now = 1'b1;
         forced    = it.force_req;
      end
      if (flush_now) begin
         run = 0;
         while (run < DEPTH && finished_flag[(head_slot + run) % DEPTH]) run++;
         if (forced || run >= flush_threshold) begin
            if (run > orb_pkg::MAX_RESULTS) run = orb_pkg::MAX_RESULTS;
            for (int unsigned k = 0; k < run; k++) begin
               slot        = (head_slot + k) % DEPTH;
               r           = '0;
               r.status    = orb_pkg::STATUS_OK;
               r.rec_valid = 1'b1;
               r.rec_out   = record_mem[slot];
               r.rec_seq   = head_seq + k;
               r.last      = (k + 1 == run);
               out_q.push_back(r);
               started_flag[slot]  = 1'b0;
               finished_flag[slot] = 1'b0;
            end
            head_seq      += run;
            head_slot      = (head_slot + run) % DEPTH;
            flushed_count += run;
         end
      end
      if (out_q.size() == 0) begin
         r        = '0;
         r.status = status;
         r.last   = 1'b1;
         out_q.push_back(r);
      end
      foreach (out_q[i]) begin
         r                = out_q[i];
         r.started_total  = started_count;
         r.finished_total = finished_count;
         r.flushed_total  = flushed_count;
         expected_rsp_q.push_back(r);
      end
   endtask

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t %s: expected %h, actual %h", $time, name, want, got);
      end
   endfunction

   task automatic check_result(input orb_pkg::rsp_type got);
      orb_pkg::rsp_type want;
      results_checked++;
      if (expected_rsp_q.size() == 0) begin
         mismatch_count++;
         $display("%0t result item: expected none, actual %h", $time, got);
      end else begin
         want = expected_rsp_q.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("rec_valid", want.rec_valid, got.rec_valid);
         compare_field("rec_out", want.rec_out, got.rec_out);
         compare_field("rec_seq", want.rec_seq, got.rec_seq);
         compare_field("last", want.last, got.last);
         compare_field("started_total", want.started_total, got.started_total);
         compare_field("finished_total", want.finished_total, got.finished_total);
         compare_field("flushed_total", want.flushed_total, got.flushed_total);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (started_flag[i]) begin
            started_flag[i]  = 1'b0;
            finished_flag[i] = 1'b0;
            record_mem[i]    = '0;
         end
         head_seq        = '0;
         head_slot       = 0;
         started_count   = '0;
         finished_count  = '0;
         flushed_count   = '0;
         flush_threshold = orb_pkg::THRESH_RESET;
         expected_rsp_q.delete();
         mismatch_count  = 0;
         results_checked = 0;
      end else begin
         if (csr_wr_en) flush_threshold = csr_wr_data;
         if (req_valid && !req_stall) predict_release(req_data);
         if (rsp_valid && !rsp_stall) check_result(rsp_data);
      end
      pending_results = expected_rsp_q.size();
      window_head     = head_seq;
   end

endmodule

FILE: tb/output_reorder_buffer_tb.sv
// testbench top: clock, reset, command stimulus, output stalls and the final verdict
module output_reorder_buffer_tb;

   localparam int unsigned DEPTH      = 32;
   localparam logic [1:0]  CMD_UNUSED = 2'd3;
   localparam int unsigned HOLD_CYCLES = 400;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   orb_pkg::req_type             req_data = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   orb_pkg::rsp_type             rsp_data;
   logic                         csr_wr_en = 1'b0;
   logic [orb_pkg::THRESH_W-1:0] csr_wr_data = '0;

   int                  mismatch_count;
   int                  pending_results;
   int                  results_checked;
   logic [31:0]         window_head;

   logic                quiet_phase = 1'b0;
   logic                fill_phase = 1'b0;
   int unsigned         items_sent = 0;
   int unsigned         settings_used = 1;
   int unsigned         phase_start;

   bit                  held = 1'b0;
   int unsigned         hold_left = 0;

   always #2 clock = ~clock;

   output_reorder_buffer #(.WINDOW_DEPTH(DEPTH)) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   orb_release_checker #(.DEPTH(DEPTH)) i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results),
      .results_checked (results_checked),
      .window_head     (window_head)
   );

   function automatic orb_pkg::req_type make_item(logic [1:0] cmd, logic [31:0] seq_id,
                                                  logic [31:0] handle, logic force_req);
      orb_pkg::req_type it;
      it.cmd           = cmd;
      it.seq_id        = seq_id;
      it.record_handle = handle;
      it.force_req     = force_req;
      return it;
   endfunction

   // ids near the head or anywhere in the id space, in equal parts
   function automatic orb_pkg::req_type random_noise();
      logic [31:0] seq_id;
      if ($urandom_range(1) == 0) seq_id = $urandom;
      else seq_id = window_head + $urandom_range(43) - 3;
      return make_item(2'($urandom_range(3)), seq_id, $urandom, 1'($urandom_range(1)));
   endfunction

   function automatic int unsigned pick_size();
      if ($urandom_range(7) == 0) return $urandom_range(9, 16);
      return $urandom_range(1, 4);
   endfunction

   // starts and ends at a falling edge
   task automatic send_item(input orb_pkg::req_type it);
      if (!quiet_phase && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_threshold(input logic [orb_pkg::THRESH_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   // begin a block of ids from the head, finish them in random order, then flush
   task automatic run_batch(input int unsigned size, input bit forced_end, input bit noisy);
      logic [31:0] base;
      logic [31:0] open_ids [$];
      logic [31:0] id;
      int unsigned pick;
      base = window_head;
      for (int unsigned i = 0; i < size; i++) begin
         send_item(make_item(orb_pkg::CMD_BEGIN, base + i, $urandom, 1'($urandom_range(1))));
         open_ids.push_back(base + i);
         if (noisy && $urandom_range(9) == 0) send_item(random_noise());
      end
      while (open_ids.size() > 0) begin
         pick = $urandom_range(open_ids.size() - 1);
         id   = open_ids[pick];
         open_ids.delete(pick);
         send_item(make_item(orb_pkg::CMD_FINISH, id, $urandom, 1'($urandom_range(1))));
         if (noisy && $urandom_range(9) == 0)
            send_item(make_item(orb_pkg::CMD_FINISH, id, $urandom, 1'b0));
         if (noisy && $urandom_range(9) == 0) send_item(random_noise());
      end
      send_item(make_item(orb_pkg::CMD_FLUSH, $urandom, $urandom, forced_end));
   endtask

   task automatic random_phase(input int unsigned count);
      phase_start = items_sent;
      while (items_sent - phase_start < count)
         run_batch(pick_size(), 1'($urandom_range(1)), 1'b1);
   endtask

   // output side: random stalls, one long hold-off when the window fill starts
   initial begin
      forever begin
         @(negedge clock);
         if (fill_phase && !held) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (quiet_phase) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 6);
         end
      end
   end

   initial begin
      #2000000;
      $display("timeout waiting for the block");
      $display("Mismatches found");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part at the reset threshold
      send_item(make_item(orb_pkg::CMD_BEGIN, 32'd0, 32'h1234_5678, 1'b1));
      send_item(make_item(orb_pkg::CMD_FINISH, 32'd0, 32'hFFFF_FFFF, 1'b1));
      send_item(make_item(orb_pkg::CMD_FINISH, 32'd0, 32'h0000_0000, 1'b0));
      send_item(make_item(orb_pkg::CMD_FINISH, 32'd5, 32'hDEAD_BEEF, 1'b0));
      send_item(make_item(orb_pkg::CMD_BEGIN, 32'd31, 32'h0, 1'b0));
      send_item(make_item(orb_pkg::CMD_BEGIN, 32'd32, 32'h0, 1'b0));
      send_item(make_item(orb_pkg::CMD_BEGIN, 32'h8000_0000, 32'h0, 1'b0));
      send_item(make_item(orb_pkg::CMD_BEGIN, 32'h7FFF_FFFF, 32'h0, 1'b0));
      send_item(make_item(orb_pkg::CMD_FINISH, 32'hFFFF_FFFF, 32'h0, 1'b0));
      send_item(make_item(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
      send_item(make_item(orb_pkg::CMD_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
      send_item(make_item(orb_pkg::CMD_FLUSH, 32'h0, 32'h0, 1'b1));
      send_item(make_item(orb_pkg::CMD_FLUSH, 32'h0, 32'h0, 1'b1));
      send_item(make_item(orb_pkg::CMD_BEGIN, 32'd0, 32'h0, 1'b0));
      send_item(make_item(orb_pkg::CMD_BEGIN, 32'd1, 32'h0, 1'b0));
      send_item(make_item(orb_pkg::CMD_BEGIN, 32'd1, 32'h0, 1'b0));
      send_item(make_item(orb_pkg::CMD_FINISH, 32'd31, 32'hA5A5_A5A5, 1'b0));
      send_item(make_item(orb_pkg::CMD_BEGIN, 32'd31, 32'h0, 1'b0));
      send_item(make_item(orb_pkg::CMD_FINISH, 32'd31, 32'h5A5A_5A5A, 1'b0));
      send_item(make_item(orb_pkg::CMD_FINISH, 32'd1, 32'h0000_0000, 1'b0));
      send_item(make_item(orb_pkg::CMD_FLUSH, 32'h0, 32'h0, 1'b1));
      send_item(make_item(orb_pkg::CMD_BEGIN, 32'd2, 32'h0, 1'b0));
      send_item(make_item(orb_pkg::CMD_FINISH, 32'd2, 32'hFFFF_0000, 1'b0));
      send_item(make_item(orb_pkg::CMD_FLUSH, 32'h0, 32'h0, 1'b1));
      wait_idle();

      // every finish at the head releases, no idling on either side
      write_threshold(6'd1);
      quiet_phase <= 1'b1;
      random_phase(8);
      wait_idle();
      quiet_phase <= 1'b0;

      // whole window under a long output hold-off, one release of the full run
      write_threshold(6'd32);
      fill_phase <= 1'b1;
      run_batch(DEPTH, 1'b0, 1'b0);
      wait_idle();

      write_threshold(6'd0);
      random_phase(4);
      wait_idle();

      write_threshold(6'd63);
      random_phase(4);
      wait_idle();

      write_threshold(6'($urandom_range(2, 31)));
      random_phase(4);
      wait_idle();
      repeat (20) @(negedge clock);

      $display("sent %0d items under %0d threshold settings, including a full window release",
               items_sent, settings_used);
      $display("compared %0d result items against the prediction", results_checked);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
